// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, clocked on clk_i, off during reset
`define ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("assertion failed");

// implication in the next cycle
`define ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

// ----- rtl/ntc_pkg.sv -----
// types and constants of the numeric type converter
package ntc_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  localparam logic [2:0] KIND_BOOL = 3'd0;
  localparam logic [2:0] KIND_I8   = 3'd1;
  localparam logic [2:0] KIND_I16  = 3'd2;
  localparam logic [2:0] KIND_I32  = 3'd3;
  localparam logic [2:0] KIND_I64  = 3'd4;
  localparam logic [2:0] KIND_F32  = 3'd5;
  localparam logic [2:0] KIND_F64  = 3'd6;

  localparam logic [1:0] REG_SRC_KIND = 2'd0;
  localparam logic [1:0] REG_DST_KIND = 2'd1;
  localparam logic [1:0] REG_THROW    = 2'd2;

  typedef struct packed {
    logic [2:0] src_kind;
    logic [2:0] dst_kind;
    logic       throw_ovf;
  } cfg_t;

  typedef struct packed {
    logic [DataW-1:0] dst_value;
    logic             dst_valid;
    logic             overflow_error;
  } result_t;

endpackage

// ----- rtl/ntc_if.sv -----
// stream interfaces for source elements and converted results
interface ntc_src_if;
  logic        valid;
  logic        ready;
  logic [63:0] src_value;
  logic        src_valid;
  modport source (output valid, src_value, src_valid, input ready);
  modport sink (input valid, src_value, src_valid, output ready);
endinterface

interface ntc_dst_if;
  logic        valid;
  logic        ready;
  logic [63:0] dst_value;
  logic        dst_valid;
  logic        overflow_error;
  modport source (output valid, dst_value, dst_valid, overflow_error, input ready);
  modport sink (input valid, dst_value, dst_valid, overflow_error, output ready);
endinterface

// ----- rtl/ntc_convert.sv -----
// combinational kind conversion of one element
module ntc_convert (
  input  ntc_pkg::cfg_t              cfg_i,
  input  logic [ntc_pkg::DataW-1:0]  value_i,
  input  logic                       valid_i,
  output ntc_pkg::result_t           result_o
);
  import ntc_pkg::*;

  function automatic logic [63:0] sext_k(logic [63:0] v, logic [2:0] k);
    case (k)
      KIND_I8:  return {{56{v[7]}}, v[7:0]};
      KIND_I16: return {{48{v[15]}}, v[15:0]};
      KIND_I32: return {{32{v[31]}}, v[31:0]};
      default:  return v;
    endcase
  endfunction

  function automatic logic [6:0] lzc64(logic [63:0] x);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

  // signed integer to binary32 or binary64, round to nearest even
  function automatic logic [63:0] int_to_fp(logic [63:0] s, logic to_f32);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] norm;
    logic [6:0]  lz;
    logic [10:0] e;
    logic [10:0] e32;
    logic [30:0] base32;
    logic [62:0] base64;
    logic        inc;
    neg  = s[63];
    mag  = neg ? (~s + 64'd1) : s;
    lz   = lzc64(mag);
    norm = mag << lz[5:0];
    e    = 11'd63 - {4'd0, lz};
    e32  = e + 11'd127;
    if (mag == 64'd0) return 64'd0;
    if (to_f32) begin
      base32 = {e32[7:0], norm[62:40]};
      inc    = norm[39] & ((|norm[38:0]) | norm[40]);
      return {32'd0, neg, base32 + {30'd0, inc}};
    end
    base64 = {e + 11'd1023, norm[62:11]};
    inc    = norm[10] & ((|norm[9:0]) | norm[11]);
    return {neg, base64 + {62'd0, inc}};
  endfunction

  // exact widening; nan gets its quiet bit
  function automatic logic [63:0] f32_to_f64(logic [31:0] b);
    logic        s;
    logic [7:0]  ex;
    logic [22:0] m;
    logic [6:0]  lz;
    logic [22:0] shm;
    s  = b[31];
    ex = b[30:23];
    m  = b[22:0];
    lz = lzc64({m, 41'd0});
    shm = m << (lz[4:0] + 5'd1);
    if (ex == 8'hFF) begin
      if (m == 23'd0) return {s, 11'h7FF, 52'd0};
      return {s, 11'h7FF, 1'b1, m[21:0], 29'd0};
    end
    if (ex == 8'd0) begin
      if (m == 23'd0) return {s, 63'd0};
      return {s, 11'd896 - {4'd0, lz}, shm, 29'd0};
    end
    return {s, {3'd0, ex} + 11'd896, m, 29'd0};
  endfunction

  // binary64 to binary32, round to nearest even, overflow to infinity
  function automatic logic [31:0] f64_to_f32(logic [63:0] d);
    logic               s;
    logic [10:0]        ex;
    logic [52:0]        sig;
    logic signed [12:0] ee;
    logic signed [12:0] diff;
    logic [5:0]         t;
    logic [52:0]        keep;
    logic [53:0]        gbits;
    logic [63:0]        mask;
    logic               st;
    logic [12:0]        eb;
    logic [30:0]        base;
    logic               inc;
    s    = d[63];
    ex   = d[62:52];
    sig  = {ex != 11'd0, d[51:0]};
    ee   = (ex == 11'd0) ? -13'sd1022 : ($signed({2'b00, ex}) - 13'sd1023);
    diff = -13'sd126 - ee;
    if (ee >= -13'sd126) t = 6'd29;
    else if (diff > 13'sd34) t = 6'd63;
    else t = 6'd29 + diff[5:0];
    keep  = sig >> t;
    gbits = {sig, 1'b0} >> t;
    mask  = (64'd1 << (t - 6'd1)) - 64'd1;
    st    = |({11'd0, sig} & mask);
    eb    = ee + 13'sd127;
    if (ex == 11'h7FF) begin
      if (d[51:0] == 52'd0) return {s, 8'hFF, 23'd0};
      return {s, 8'hFF, 1'b1, d[50:29]};
    end
    if (ee > 13'sd127) return {s, 8'hFF, 23'd0};
    base = (ee >= -13'sd126) ? {eb[7:0], keep[22:0]} : {8'd0, keep[22:0]};
    inc  = gbits[0] & (st | keep[0]);
    return {s, base + {30'd0, inc}};
  endfunction

  logic [63:0]        u;
  logic [63:0]        dd;
  logic               is_float;
  logic               kinds_ok;
  logic [10:0]        dex;
  logic [52:0]        dsig;
  logic signed [12:0] dee;
  logic               in_range;
  logic [63:0]        mag;
  logic [63:0]        trunc;
  logic [63:0]        iv;
  logic [63:0]        res;
  logic               ovf;

  always_comb begin
    case (cfg_i.src_kind)
      KIND_BOOL: u = {63'd0, value_i[0]};
      KIND_I8, KIND_I16, KIND_I32, KIND_I64: u = sext_k(value_i, cfg_i.src_kind);
      default:   u = 64'd0;
    endcase
    is_float = (cfg_i.src_kind == KIND_F32) || (cfg_i.src_kind == KIND_F64);
    dd = (cfg_i.src_kind == KIND_F32) ? f32_to_f64(value_i[31:0]) : value_i;

    // truncation of the double toward zero
    dex  = dd[62:52];
    dsig = {dex != 11'd0, dd[51:0]};
    dee  = $signed({2'b00, dex}) - 13'sd1023;
    in_range = (dex < 11'd1086) || (dd == 64'hC3E0_0000_0000_0000);
    if (dex < 11'd1023) mag = 64'd0;
    else if (dee >= 13'sd52) mag = {11'd0, dsig} << (dee[5:0] - 6'd52);
    else mag = {11'd0, dsig} >> (6'd52 - dee[5:0]);
    trunc = dd[63] ? (~mag + 64'd1) : mag;

    kinds_ok = (cfg_i.src_kind <= KIND_F64) && (cfg_i.dst_kind <= KIND_F64);
    iv  = is_float ? trunc : u;
    ovf = 1'b0;
    res = 64'd0;
    if (cfg_i.src_kind == cfg_i.dst_kind) begin
      if (cfg_i.src_kind == KIND_F32) res = {32'd0, value_i[31:0]};
      else if (cfg_i.src_kind == KIND_F64) res = value_i;
      else res = u;
    end else begin
      case (cfg_i.dst_kind)
        KIND_BOOL: begin
          if (is_float) res = {63'd0, dex >= 11'd1023};
          else res = {63'd0, u != 64'd0};
        end
        KIND_F32: res = is_float ? {32'd0, f64_to_f32(dd)} : int_to_fp(u, 1'b1);
        KIND_F64: res = is_float ? dd : int_to_fp(u, 1'b0);
        default: begin
          res = iv;
          ovf = (is_float && !in_range) || (sext_k(iv, cfg_i.dst_kind) != iv);
        end
      endcase
    end

    result_o = '0;
    if (valid_i && kinds_ok) begin
      if (ovf) begin
        result_o.overflow_error = cfg_i.throw_ovf;
      end else begin
        result_o.dst_value = res;
        result_o.dst_valid = 1'b1;
      end
    end
  end

endmodule

// ----- rtl/numeric_type_converter_top.sv -----
// Numeric type converter: turns one column element per beat from the configured
// source kind (boolean, int8..int64, binary32, binary64) into the destination kind,
// with range checks on integer results. An element is taken into an input register,
// converted by combinational logic and held in an output register, so one beat is
// accepted every cycle while the output side does not stall. A result moves through
// the conversion logic into the output register, which holds it until the output
// side accepts it; a stalled output holds its result while the input register still
// takes one more beat. Kind and overflow registers sit on the APB port at byte
// offsets 0, 4, 8 and must only be written while the stream is idle.
module numeric_type_converter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ntc_src_if.sink                       src_i,
  ntc_dst_if.source                     dst_o,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [ntc_pkg::ApbAddrW-1:0]  paddr_i,
  input  logic [ntc_pkg::ApbDataW-1:0]  pwdata_i,
  output logic [ntc_pkg::ApbDataW-1:0]  prdata_o,
  output logic                          pready_o
);
  import ntc_pkg::*;

  cfg_t             cfg_q;
  logic             wr_en;

  logic             s1_v_q, s1_v_d;
  logic [DataW-1:0] s1_value_q;
  logic             s1_valid_q;
  logic             out_v_q, out_v_d;
  result_t          out_q;
  result_t          conv;
  logic             out_adv;
  logic             in_take;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_kind  <= KIND_BOOL;
      cfg_q.dst_kind  <= KIND_I64;
      cfg_q.throw_ovf <= 1'b0;
    end else if (wr_en) begin
      case (paddr_i[3:2])
        REG_SRC_KIND: cfg_q.src_kind  <= pwdata_i[2:0];
        REG_DST_KIND: cfg_q.dst_kind  <= pwdata_i[2:0];
        REG_THROW:    cfg_q.throw_ovf <= pwdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr_i[3:2])
      REG_SRC_KIND: prdata_o = {29'd0, cfg_q.src_kind};
      REG_DST_KIND: prdata_o = {29'd0, cfg_q.dst_kind};
      REG_THROW:    prdata_o = {31'd0, cfg_q.throw_ovf};
      default:      prdata_o = '0;
    endcase
  end

  // output register frees when empty or taken; input stage moves on then or when empty
  assign out_adv     = !out_v_q || dst_o.ready;
  assign in_take     = !s1_v_q || out_adv;
  assign src_i.ready = in_take;

  always_comb begin
    s1_v_d  = in_take ? src_i.valid : s1_v_q;
    out_v_d = out_adv ? s1_v_q : out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && src_i.valid) begin
      s1_value_q <= src_i.src_value;
      s1_valid_q <= src_i.src_valid;
    end
    if (out_adv && s1_v_q) begin
      out_q <= conv;
    end
  end

  ntc_convert u_convert (
    .cfg_i    (cfg_q),
    .value_i  (s1_value_q),
    .valid_i  (s1_valid_q),
    .result_o (conv)
  );

  assign dst_o.valid          = out_v_q;
  assign dst_o.dst_value      = out_q.dst_value;
  assign dst_o.dst_valid      = out_q.dst_valid;
  assign dst_o.overflow_error = out_q.overflow_error;

endmodule

// ----- rtl/ntc_checker.sv -----
// port-level checks on the converter output stream
`include "assert_macros.svh"

module ntc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] dst_value_i,
  input logic        dst_valid_i,
  input logic        overflow_error_i
);

  // a waiting result stays and keeps its payload
  `ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(dst_value_i))
  // an error beat is never also a valid result
  `ASSERT_NOW(a_err_excl, out_valid_i, !(dst_valid_i && overflow_error_i))
  // null or overflow results carry a zero value
  `ASSERT_NOW(a_null_zero, out_valid_i && !dst_valid_i, dst_value_i == 64'd0)

endmodule

bind numeric_type_converter_top ntc_checker u_ntc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (dst_o.valid),
  .out_ready_i      (dst_o.ready),
  .dst_value_i      (dst_o.dst_value),
  .dst_valid_i      (dst_o.dst_valid),
  .overflow_error_i (dst_o.overflow_error)
);

// ----- tb/tb.sv -----
// self-checking testbench for the numeric type converter: directed table, then random phases
module tb;
  import ntc_pkg::*;

  localparam logic [2:0] KIND_NONE = 3'd7;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [63:0] value;
    logic        valid;
    logic        err;
  } conv_res_t;

  typedef struct packed {
    logic [2:0]  sk;
    logic [2:0]  dk;
    logic        thr;
    logic [63:0] value;
    logic        vb;
    logic        typed;
    conv_res_t   res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic psel_i, penable_i, pwrite_i;
  logic [ApbAddrW-1:0] paddr_i;
  logic [ApbDataW-1:0] pwdata_i;
  logic [ApbDataW-1:0] prdata_o;
  logic pready_o;

  ntc_src_if src_bus();
  ntc_dst_if dst_bus();

  numeric_type_converter_top dut (
    .clk_i, .rst_ni, .src_i(src_bus), .dst_o(dst_bus),
    .psel_i, .penable_i, .pwrite_i, .paddr_i, .pwdata_i, .prdata_o, .pready_o
  );

  logic [2:0] cfg_src_kind = KIND_BOOL;
  logic [2:0] cfg_dst_kind = KIND_I64;
  logic       cfg_throw    = 1'b0;

  conv_res_t pending_res[$];
  int unsigned err_cnt = 0;
  int unsigned cyc_cnt = 0;
  int unsigned stall_left = 0;
  bit calm = 0;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------- conversion predictor ----------------
  function automatic logic [63:0] sext_kind(logic [63:0] u, logic [2:0] k);
    case (k)
      KIND_I8:  return {{56{u[7]}}, u[7:0]};
      KIND_I16: return {{48{u[15]}}, u[15:0]};
      KIND_I32: return {{32{u[31]}}, u[31:0]};
      default:  return u;
    endcase
  endfunction

  function automatic int msb_pos(logic [63:0] x);
    int p;
    p = 0;
    for (int i = 0; i < 64; i++) if (x[i]) p = i;
    return p;
  endfunction

  // shift right by sh with round to nearest even
  function automatic logic [63:0] rne_shift(logic [63:0] sig, int sh);
    logic [63:0] q, rem, half;
    if (sh <= 0) return sig;
    q = sig >> sh;
    rem = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q;
  endfunction

  function automatic logic [63:0] int_to_fp(logic [63:0] u, bit dbl);
    logic s;
    logic [63:0] mag, q;
    int p, mb;
    s = u[63];
    mag = s ? -u : u;
    if (mag == 0) return 64'd0;
    p = msb_pos(mag);
    mb = dbl ? 52 : 23;
    if (p <= mb) q = mag << (mb - p);
    else q = rne_shift(mag, p - mb);
    if ((q >> (mb + 1)) != 0) begin
      q = q >> 1;
      p++;
    end
    if (dbl) return {s, 11'(p + 1023), q[51:0]};
    return {32'd0, s, 8'(p + 127), q[22:0]};
  endfunction

  function automatic logic [63:0] f32_to_f64(logic [31:0] b);
    logic s;
    logic [7:0] e;
    logic [22:0] m;
    logic [63:0] mm;
    int p;
    s = b[31];
    e = b[30:23];
    m = b[22:0];
    if (e == 8'hff) begin
      if (m != 0) return {s, 11'h7ff, 1'b1, m[21:0], 29'd0};
      return {s, 11'h7ff, 52'd0};
    end
    if (e == 0) begin
      if (m == 0) return {s, 63'd0};
      p = msb_pos({41'd0, m});
      mm = {41'd0, m} << (52 - p);
      return {s, 11'(p - 149 + 1023), mm[51:0]};
    end
    return {s, 11'(int'(e) - 127 + 1023), m, 29'd0};
  endfunction

  function automatic logic [63:0] f64_to_f32(logic [63:0] d);
    logic s;
    logic [10:0] e;
    logic [51:0] m;
    logic [63:0] sig, q;
    logic [31:0] bits;
    int ex, sh;
    s = d[63];
    e = d[62:52];
    m = d[51:0];
    if (e == 11'h7ff) begin
      if (m != 0) return {32'd0, s, 8'hff, 1'b1, m[50:29]};
      return {32'd0, s, 8'hff, 23'd0};
    end
    if (e == 0 && m == 0) return {32'd0, s, 31'd0};
    ex = (e == 0) ? -1022 : int'(e) - 1023;
    sig = {11'd0, e != 0, m};
    if (ex > 127) return {32'd0, s, 8'hff, 23'd0};
    if (ex >= -126) begin
      q = rne_shift(sig, 29);
      bits = 32'((ex + 127) << 23) + q[31:0] - 32'h0080_0000;
    end else begin
      sh = 29 + (-126 - ex);
      bits = (sh >= 54) ? 32'd0 : 32'(rne_shift(sig, sh));
    end
    return {32'd0, s, bits[30:0]};
  endfunction

  // truncate toward zero; ok low when outside the int64 range or nan
  function automatic logic [63:0] fp_to_int(logic [63:0] d, output bit ok);
    logic s;
    logic [10:0] e;
    logic [63:0] sig, mag;
    int ex;
    s = d[63];
    e = d[62:52];
    ok = 1;
    if (e == 11'h7ff) begin
      ok = 0;
      return 64'd0;
    end
    ex = int'(e) - 1023;
    if (ex < 0) return 64'd0;
    if (ex >= 63) begin
      ok = (s && ex == 63 && d[51:0] == 0);
      return ok ? 64'h8000_0000_0000_0000 : 64'd0;
    end
    sig = {11'd0, 1'b1, d[51:0]};
    mag = (ex >= 52) ? sig << (ex - 52) : sig >> (52 - ex);
    return s ? -mag : mag;
  endfunction

  function automatic conv_res_t convert(logic [63:0] v, logic vb);
    conv_res_t r;
    logic [63:0] u, d, res;
    bit is_fp, ovf, ok;
    r = '0;
    if (!vb || cfg_src_kind == KIND_NONE || cfg_dst_kind == KIND_NONE) return r;
    is_fp = 0;
    ovf = 0;
    u = 0;
    d = 0;
    if (cfg_src_kind == KIND_BOOL) u = {63'd0, v[0]};
    else if (cfg_src_kind <= KIND_I64) u = sext_kind(v, cfg_src_kind);
    else begin
      is_fp = 1;
      d = (cfg_src_kind == KIND_F32) ? f32_to_f64(v[31:0]) : v;
    end
    if (cfg_src_kind == cfg_dst_kind) begin
      if (cfg_src_kind == KIND_F32) res = {32'd0, v[31:0]};
      else if (cfg_src_kind == KIND_F64) res = v;
      else res = u;
    end else if (cfg_dst_kind == KIND_BOOL) begin
      if (is_fp) res = {63'd0, (d[62:52] == 11'h7ff || d[62:52] >= 11'd1023)};
      else res = {63'd0, (u != 0)};
    end else if (cfg_dst_kind <= KIND_I64) begin
      if (is_fp) begin
        u = fp_to_int(d, ok);
        ovf = !ok;
      end
      if (!ovf && sext_kind(u, cfg_dst_kind) != u) ovf = 1;
      res = u;
    end else if (cfg_dst_kind == KIND_F32) begin
      res = is_fp ? f64_to_f32(d) : int_to_fp(u, 0);
    end else begin
      res = is_fp ? d : int_to_fp(u, 1);
    end
    if (ovf) begin
      r.err = cfg_throw;
      return r;
    end
    r.value = res;
    r.valid = 1;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic int gap_len();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 30);
    return $urandom_range(1, 3);
  endfunction

  task automatic apb_write(logic [ApbAddrW-1:0] addr, logic [31:0] data);
    psel_i <= 1;
    penable_i <= 0;
    pwrite_i <= 1;
    paddr_i <= addr;
    pwdata_i <= data;
    @(negedge clk_i);
    penable_i <= 1;
    do @(posedge clk_i); while (!pready_o);
    @(negedge clk_i);
    psel_i <= 0;
    penable_i <= 0;
    pwrite_i <= 0;
  endtask

  task automatic drain();
    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic set_kinds(logic [2:0] sk, logic [2:0] dk, logic thr);
    if (sk == cfg_src_kind && dk == cfg_dst_kind && thr == cfg_throw) return;
    src_bus.valid <= 0;
    drain();
    apb_write({REG_SRC_KIND, 2'b00}, {29'd0, sk});
    apb_write({REG_DST_KIND, 2'b00}, {29'd0, dk});
    apb_write({REG_THROW, 2'b00}, {31'd0, thr});
    cfg_src_kind = sk;
    cfg_dst_kind = dk;
    cfg_throw = thr;
  endtask

  // caller sits at a falling edge; returns at a falling edge
  task automatic send_elem(logic [63:0] v, logic vb, bit typed, conv_res_t res);
    int g;
    src_bus.valid <= 1;
    src_bus.src_value <= v;
    src_bus.src_valid <= vb;
    do @(posedge clk_i); while (!src_bus.ready);
    pending_res.push_back(typed ? res : convert(v, vb));
    @(negedge clk_i);
    g = gap_len();
    if (g > 0) begin
      src_bus.valid <= 0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  function automatic logic [63:0] rand_value(logic [2:0] sk);
    logic [63:0] v;
    logic [10:0] e64;
    logic [7:0] e32;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 1: return v;
      2: return 64'($signed($urandom_range(0, 600)) - 300);
      3: return {{32{v[40]}}, v[31:0]} >> $urandom_range(0, 63);
      default: begin
        case ($urandom_range(0, 14))
          0: begin e64 = 0;      e32 = 0;   end
          1: begin e64 = 1;      e32 = 1;   end
          2: begin e64 = 11'h3fe; e32 = 126; end
          3: begin e64 = 11'h3ff; e32 = 127; end
          4: begin e64 = 11'h400; e32 = 128; end
          5: begin e64 = 1030;   e32 = 134; end
          6: begin e64 = 1031;   e32 = 135; end
          7: begin e64 = 1038;   e32 = 142; end
          8: begin e64 = 1039;   e32 = 143; end
          9: begin e64 = 1054;   e32 = 158; end
          10: begin e64 = 1055;  e32 = 159; end
          11: begin e64 = 1085;  e32 = 190; end
          12: begin e64 = 1086;  e32 = 191; end
          13: begin e64 = 11'h47e; e32 = 254; end
          default: begin e64 = 11'h7ff; e32 = 255; end
        endcase
        if ($urandom_range(0, 5) == 0) v[51:0] = 0;
        if (sk == KIND_F32) return {v[63:32], v[31], e32, v[22:0]};
        if (sk == KIND_F64 && $urandom_range(0, 3) == 0)
          return {v[63], 11'(int'(e64) - 1023 + 897), v[51:0]};
        return {v[63], e64, v[51:0]};
      end
    endcase
  endfunction

  function automatic logic [2:0] rand_kind();
    if ($urandom_range(0, 15) == 0) return KIND_NONE;
    return 3'($urandom_range(0, 6));
  endfunction

  dir_row_t dir_tab[] = '{
    '{KIND_BOOL, KIND_I64, 0, 64'h1, 1, 1, '{64'h1, 1, 0}},
    '{KIND_BOOL, KIND_I64, 0, 64'hFFFF_FFFF_FFFF_FFFE, 1, 1, '{64'h0, 1, 0}},
    '{KIND_I64, KIND_I8, 0, 64'h7F, 1, 1, '{64'h7F, 1, 0}},
    '{KIND_I64, KIND_I8, 0, 64'h80, 1, 1, '{64'h0, 0, 0}},
    '{KIND_I64, KIND_I8, 1, 64'h80, 1, 1, '{64'h0, 0, 1}},
    '{KIND_I64, KIND_I8, 1, 64'hFFFF_FFFF_FFFF_FF80, 1, 1, '{64'hFFFF_FFFF_FFFF_FF80, 1, 0}},
    '{KIND_I8, KIND_I64, 0, 64'h80, 1, 1, '{64'hFFFF_FFFF_FFFF_FF80, 1, 0}},
    '{KIND_I16, KIND_I32, 0, 64'hABCD_8000, 1, 1, '{64'hFFFF_FFFF_FFFF_8000, 1, 0}},
    '{KIND_I32, KIND_I16, 1, 64'h8000_0000, 1, 1, '{64'h0, 0, 1}},
    '{KIND_I64, KIND_F64, 0, 64'h8000_0000_0000_0000, 1, 0, '0},
    '{KIND_I64, KIND_F32, 0, 64'h7FFF_FFFF_FFFF_FFFF, 1, 0, '0},
    '{KIND_F64, KIND_I64, 0, 64'h43E0_0000_0000_0000, 1, 1, '{64'h0, 0, 0}},
    '{KIND_F64, KIND_I64, 1, 64'hC3E0_0000_0000_0000, 1, 1, '{64'h8000_0000_0000_0000, 1, 0}},
    '{KIND_F64, KIND_I64, 1, 64'h7FF8_0000_0000_0000, 1, 1, '{64'h0, 0, 1}},
    '{KIND_F64, KIND_BOOL, 0, 64'h7FF8_0000_0000_0000, 1, 1, '{64'h1, 1, 0}},
    '{KIND_F64, KIND_BOOL, 0, 64'h3FEF_FFFF_FFFF_FFFF, 1, 1, '{64'h0, 1, 0}},
    '{KIND_F64, KIND_BOOL, 0, 64'hBFF0_0000_0000_0000, 1, 1, '{64'h1, 1, 0}},
    '{KIND_F64, KIND_F32, 0, 64'h47EF_FFFF_F000_0000, 1, 1, '{64'h7F80_0000, 1, 0}},
    '{KIND_F64, KIND_F32, 0, 64'hC7EF_FFFF_E800_0000, 1, 1, '{64'hFF7F_FFFF, 1, 0}},
    '{KIND_F32, KIND_F64, 0, 64'h1, 1, 0, '0},
    '{KIND_F32, KIND_I64, 0, 64'hFFFF_FFFF_4F00_0000, 1, 1, '{64'h8000_0000, 1, 0}},
    '{KIND_F32, KIND_I32, 1, 64'h4F00_0000, 1, 1, '{64'h0, 0, 1}},
    '{KIND_F32, KIND_F32, 0, 64'hFFFF_FFFF_7FC0_0001, 1, 1, '{64'h7FC0_0001, 1, 0}},
    '{KIND_NONE, KIND_I64, 1, 64'h5, 1, 1, '{64'h0, 0, 0}},
    '{KIND_I64, KIND_NONE, 0, 64'h5, 1, 1, '{64'h0, 0, 0}},
    '{KIND_F64, KIND_F64, 0, 64'h3FF0_0000_0000_0000, 0, 1, '{64'h0, 0, 0}}
  };

  // ---------------- sender ----------------
  initial begin
    logic [2:0] sk;
    rst_ni = 0;
    psel_i = 0;
    penable_i = 0;
    pwrite_i = 0;
    paddr_i = 0;
    pwdata_i = 0;
    src_bus.valid = 0;
    src_bus.src_value = 0;
    src_bus.src_valid = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      set_kinds(dir_tab[i].sk, dir_tab[i].dk, dir_tab[i].thr);
      send_elem(dir_tab[i].value, dir_tab[i].vb, dir_tab[i].typed, dir_tab[i].res);
    end

    // extremes of the kind codes first, then random settings
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: set_kinds(KIND_BOOL, KIND_F64, 1);
        1: set_kinds(KIND_F64, KIND_BOOL, 0);
        default: begin
          sk = rand_kind();
          set_kinds(sk, $urandom_range(0, 3) == 0 ? sk : rand_kind(), 1'($urandom));
        end
      endcase
      calm = (ph % 4 == 3);
      for (int n = 0; n < 42; n++) begin
        if (ph == 5 && n == 20) begin
          src_bus.valid <= 0;
          while (pending_res.size() != 0) @(negedge clk_i);
        end
        send_elem(rand_value(cfg_src_kind), $urandom_range(0, 9) != 0, 0, '0);
      end
    end
    src_bus.valid <= 0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  // ---------------- result side ----------------
  initial begin
    dst_bus.ready = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        dst_bus.ready <= 0;
        stall_left--;
      end else begin
        dst_bus.ready <= 1;
        if (!calm && $urandom_range(0, 3) == 0)
          stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk_i) begin
    conv_res_t want;
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
    if (rst_ni && dst_bus.valid && dst_bus.ready) begin
      if (pending_res.size() == 0) begin
        $error("unexpected beat: dst_value %h", dst_bus.dst_value);
        err_cnt++;
      end else begin
        want = pending_res.pop_front();
        if (dst_bus.dst_value !== want.value) begin
          $error("dst_value exp %h got %h", want.value, dst_bus.dst_value);
          err_cnt++;
        end
        if (dst_bus.dst_valid !== want.valid) begin
          $error("dst_valid exp %b got %b", want.valid, dst_bus.dst_valid);
          err_cnt++;
        end
        if (dst_bus.overflow_error !== want.err) begin
          $error("overflow_error exp %b got %b", want.err, dst_bus.overflow_error);
          err_cnt++;
        end
      end
    end
  end

endmodule
